// File: design/lfcc_pkg.sv
package lfcc_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned HeaderBytes = 8;
   localparam int unsigned HdrIdxWidth = $clog2(HeaderBytes);

   localparam logic [WordWidth-1:0] CrcPolyReflected = 32'hEDB8_8320;
   localparam logic [WordWidth-1:0] CrcAllOnes       = 32'hFFFF_FFFF;
   localparam logic [WordWidth-1:0] MaxLengthReset   = 32'd16777216;

   // Frame status codes carried with every result.
   localparam logic [1:0] STATUS_BODY       = 2'd0;
   localparam logic [1:0] STATUS_CRC_OK     = 2'd1;
   localparam logic [1:0] STATUS_CRC_BAD    = 2'd2;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd3;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 out_last;
      logic [1:0]           frame_status;
   } result_type;

   // One byte of the reflected CRC-32, processed a bit at a time.
   function automatic logic [WordWidth-1:0] crc_byte_update(
      input logic [WordWidth-1:0] crc,
      input logic [ByteWidth-1:0] data
   );
      logic [WordWidth-1:0] c;
      c = crc ^ {{(WordWidth-ByteWidth){1'b0}}, data};
      for (int k = 0; k < ByteWidth; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPolyReflected;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: design/lfcc_parser.sv
module lfcc_parser
   import lfcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [ByteWidth-1:0] in_byte,
   input  logic [WordWidth-1:0] max_length,
   output logic                 res_valid,
   output result_type           res
);

   logic                      in_body_ff, in_body_in;
   logic [HdrIdxWidth-1:0]    header_index_ff, header_index_in;
   logic [8*HeaderBytes-1:0]  header_shift_ff, header_shift_in;
   logic [WordWidth-1:0]      body_remaining_ff, body_remaining_in;
   logic [WordWidth-1:0]      expected_crc_ff, expected_crc_in;
   logic [WordWidth-1:0]      running_crc_ff, running_crc_in;

   logic [WordWidth-1:0]      crc_next;
   logic [WordWidth-1:0]      hdr_len;
   logic [WordWidth-1:0]      hdr_crc;
   logic                      hdr_done;
   logic                      last_byte;

   assign crc_next  = crc_byte_update(running_crc_ff, in_byte);
   assign hdr_len   = header_shift_in[WordWidth-1:0];
   assign hdr_crc   = header_shift_in[2*WordWidth-1:WordWidth];
   assign hdr_done  = (header_index_ff == HdrIdxWidth'(HeaderBytes - 1));
   assign last_byte = (body_remaining_ff == WordWidth'(1));

   always_comb begin
      in_body_in        = in_body_ff;
      header_index_in   = header_index_ff;
      header_shift_in   = header_shift_ff;
      body_remaining_in = body_remaining_ff;
      expected_crc_in   = expected_crc_ff;
      running_crc_in    = running_crc_ff;
      res_valid         = 1'b0;
      res               = '{out_byte: in_byte, out_last: 1'b0, frame_status: STATUS_BODY};

      if (!in_body_ff) begin
         // Little-endian header: each byte enters at the top and moves down.
         header_shift_in = {in_byte, header_shift_ff[8*HeaderBytes-1:ByteWidth]};
         header_index_in = header_index_ff + HdrIdxWidth'(1);
         if (hdr_done) begin
            if (hdr_len == '0 || hdr_len > max_length) begin
               body_remaining_in = '0;
               res_valid         = 1'b1;
               res = '{out_byte: '0, out_last: 1'b1, frame_status: STATUS_BAD_LENGTH};
            end else begin
               in_body_in        = 1'b1;
               body_remaining_in = hdr_len;
               expected_crc_in   = hdr_crc;
               running_crc_in    = CrcAllOnes;
            end
         end
      end else begin
         res_valid         = 1'b1;
         body_remaining_in = body_remaining_ff - WordWidth'(1);
         running_crc_in    = crc_next;
         if (last_byte) begin
            res.out_last     = 1'b1;
            res.frame_status = ((crc_next ^ CrcAllOnes) == expected_crc_ff) ?
                               STATUS_CRC_OK : STATUS_CRC_BAD;
            in_body_in       = 1'b0;
            header_index_in  = '0;
            running_crc_in   = CrcAllOnes;
         end
      end

      if (!accept) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff        <= 1'b0;
         header_index_ff   <= '0;
         body_remaining_ff <= '0;
         running_crc_ff    <= CrcAllOnes;
      end else if (accept) begin
         in_body_ff        <= in_body_in;
         header_index_ff   <= header_index_in;
         body_remaining_ff <= body_remaining_in;
         running_crc_ff    <= running_crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         header_shift_ff <= header_shift_in;
         expected_crc_ff <= expected_crc_in;
      end
   end

endmodule

// File: design/length_crc32_frame_checker.sv
// Length-prefixed frame checker with CRC-32.
// The request channel (req_valid, req_stall, req_in_byte) carries a byte stream
// of frames: an 8-byte header holding a little-endian body length and then a
// little-endian expected CRC, followed by the body. A transfer takes place on
// a rising edge where valid is high and stall is low.
// Header bytes give no result. A length of zero, or one above the maximum set
// through the csr_ port, gives one error transfer and the block waits for a
// fresh header. Each body byte is passed through on the response channel and
// the last one reports whether the zlib CRC-32 of the body matched.
// Throughput is one byte per cycle while req_stall is low: the CRC byte
// update and the header and length logic sit between the frame state
// registers and the response register. A skid register behind the response
// register lets a byte be taken while a result is still waiting, so req_stall
// only rises once both are full under a stalled receiver; pending results
// are held unchanged until taken. Reset is synchronous and active high: it
// empties both result registers, restores the maximum length to its default
// and returns the parser to expecting a header. A new maximum applies at the
// next header.
module length_crc32_frame_checker
   import lfcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_wr_en,
   input  logic [WordWidth-1:0] csr_wr_data,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_in_byte,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ByteWidth-1:0] rsp_out_byte,
   output logic                 rsp_out_last,
   output logic [1:0]           rsp_frame_status
);

   logic [WordWidth-1:0] max_length_ff;

   logic       req_take;
   logic       new_valid;
   result_type new_res;

   // Response register and the skid register behind it.
   logic       out_valid_ff;
   result_type out_ff;
   logic       skid_valid_ff;
   result_type skid_ff;
   logic       out_take;

   // The skid register is only ever filled while the response register is
   // full, so a byte can always be taken as long as the skid is empty.
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MaxLengthReset;
      end else if (csr_wr_en) begin
         max_length_ff <= csr_wr_data;
      end
   end

   lfcc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_take),
      .in_byte    (req_in_byte),
      .max_length (max_length_ff),
      .res_valid  (new_valid),
      .res        (new_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            // No new result can arrive while the skid is occupied.
            if (out_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (new_valid) begin
            if (!out_valid_ff || out_take) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (new_valid) begin
         if (!out_valid_ff || out_take) begin
            out_ff <= new_res;
         end else begin
            skid_ff <= new_res;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_ff.out_byte;
   assign rsp_out_last     = out_ff.out_last;
   assign rsp_frame_status = out_ff.frame_status;

endmodule
